FILE: hw/rtl/ttint_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the trilinear table interpolator
package ttint_pkg;

  localparam int IDX_W       = 4;
  localparam int FRAC_W      = 17;
  localparam int VALUE_W     = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int NUM_BANKS   = 8;

  // what the front made of an accepted transaction
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_RANGE
  } op_t;

  // one queued transaction; for a query the cell fields hold the lower corner
  typedef struct packed {
    op_t                       op;
    logic [IDX_W-1:0]          cell_x;
    logic [IDX_W-1:0]          cell_y;
    logic [IDX_W-1:0]          cell_z;
    logic [FRAC_W-1:0]         frac_x;
    logic [FRAC_W-1:0]         frac_y;
    logic [FRAC_W-1:0]         frac_z;
    logic signed [VALUE_W-1:0] load_value;
  } queue_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ttint_front.sv
`timescale 1ns / 1ps
`default_nettype none
// front end: range checks, fraction clamping and queue push of input transactions
module ttint_front #(
  parameter int SIZE_X    = 16,
  parameter int SIZE_Y    = 16,
  parameter int SIZE_Z    = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              in_valid,
  input  wire logic                              cmd,
  input  wire logic [ttint_pkg::IDX_W-1:0]       index_x,
  input  wire logic [ttint_pkg::IDX_W-1:0]       index_y,
  input  wire logic [ttint_pkg::IDX_W-1:0]       index_z,
  input  wire logic [ttint_pkg::FRAC_W-1:0]      frac_x,
  input  wire logic [ttint_pkg::FRAC_W-1:0]      frac_y,
  input  wire logic [ttint_pkg::FRAC_W-1:0]      frac_z,
  input  wire logic signed [ttint_pkg::VALUE_W-1:0] load_value,
  input  wire ttint_pkg::queue_stat_t            stat,
  output logic                                   in_stall,
  output logic                                   push,
  output ttint_pkg::queue_item_t                 item
);
  import ttint_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] raw);
    if (longint'(raw) > ONE) return FRAC_W'(ONE);
    return raw;
  endfunction

  logic load_ok;
  logic query_ok;

  always_comb begin
    load_ok  = (int'(index_x) < SIZE_X) && (int'(index_y) < SIZE_Y) &&
               (int'(index_z) < SIZE_Z);
    query_ok = load_ok && (index_x != '0) && (index_y != '0) && (index_z != '0);
  end

  always_comb begin
    item.op         = OP_LOAD;
    item.cell_x     = index_x;
    item.cell_y     = index_y;
    item.cell_z     = index_z;
    item.frac_x     = clamp_frac(frac_x);
    item.frac_y     = clamp_frac(frac_y);
    item.frac_z     = clamp_frac(frac_z);
    item.load_value = load_value;
    if (cmd) begin
      if (query_ok) begin
        item.op     = OP_QUERY;
        item.cell_x = index_x - 1'b1;
        item.cell_y = index_y - 1'b1;
        item.cell_z = index_z - 1'b1;
      end else begin
        item.op = OP_RANGE;
      end
    end
  end

  // loads outside the table are dropped here
  assign push     = in_valid && !stat.full && (cmd || load_ok);
  assign in_stall = stat.full;

endmodule
`default_nettype wire

FILE: hw/rtl/ttint_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// short fifo between front end and interpolation back end
module ttint_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire logic                   pop,
  input  wire ttint_pkg::queue_item_t push_item,
  output ttint_pkg::queue_item_t      head,
  output ttint_pkg::queue_stat_t      stat
);
  import ttint_pkg::*;

  queue_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule
`default_nettype wire

FILE: hw/rtl/ttint_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// one table bank: single write port, registered read port
module ttint_bank #(
  parameter int AW = 9
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [AW-1:0]                 raddr,
  input  wire logic [ttint_pkg::VALUE_W-1:0] wdata,
  output logic [ttint_pkg::VALUE_W-1:0]      rdata
);
  import ttint_pkg::*;

  logic [VALUE_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ttint_back.sv
`timescale 1ns / 1ps
`default_nettype none
// back end: parity banks, three pipelined lerp levels and the output register
module ttint_back #(
  parameter int SIZE_X    = 16,
  parameter int SIZE_Y    = 16,
  parameter int SIZE_Z    = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ttint_pkg::queue_item_t            head,
  input  wire ttint_pkg::queue_stat_t            stat,
  output logic                                   pop,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic signed [ttint_pkg::VALUE_W-1:0]   interp_value,
  output logic                                   out_of_range
);
  import ttint_pkg::*;

  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int HX   = ((SIZE_X < IDX_SPAN ? SIZE_X : IDX_SPAN) + 1) / 2;
  localparam int HY   = ((SIZE_Y < IDX_SPAN ? SIZE_Y : IDX_SPAN) + 1) / 2;
  localparam int HZ   = ((SIZE_Z < IDX_SPAN ? SIZE_Z : IDX_SPAN) + 1) / 2;
  localparam int AW_X = (HX > 1) ? $clog2(HX) : 1;
  localparam int AW_Y = (HY > 1) ? $clog2(HY) : 1;
  localparam int AW_Z = (HZ > 1) ? $clog2(HZ) : 1;
  localparam int AW   = AW_X + AW_Y + AW_Z;
  localparam int FW   = FRAC_BITS + 1;
  localparam int DW   = VALUE_W + 1;
  localparam int PW   = DW + FW + 1;
  localparam int STAGES = 7;
  localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic signed [DW-1:0] diff(input logic [VALUE_W-1:0] a,
                                                input logic [VALUE_W-1:0] b);
    return {b[VALUE_W-1], b} - {a[VALUE_W-1], a};
  endfunction

  // a + floor(p / 2^FRAC_BITS); the result lies between the two lerp inputs
  function automatic logic [VALUE_W-1:0] lerp_sum(input logic [VALUE_W-1:0] a,
                                                  input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    logic [DW-1:0]        s;
    sh = p >>> FRAC_BITS;
    s  = {a[VALUE_W-1], a} + sh[DW-1:0];
    return s[VALUE_W-1:0];
  endfunction

  logic en;
  logic is_load;
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rng;
  logic [3*FW-1:0]   fr [STAGES-1];
  logic [VALUE_W-1:0] rd [NUM_BANKS];

  assign en      = !out_valid || !out_stall;
  assign pop     = en && !stat.empty;
  assign is_load = (head.op == OP_LOAD);

  // bank {bx,by,bz} holds the entries whose index parities match
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic [2:0] BSEL = 3'(b);
    logic [IDX_W-2:0] hx, hy, hz;
    logic [AW-1:0]    addr;
    logic             we;

    always_comb begin
      hx = head.cell_x[IDX_W-1:1] +
           (IDX_W - 1)'(!is_load && head.cell_x[0] && !BSEL[2]);
      hy = head.cell_y[IDX_W-1:1] +
           (IDX_W - 1)'(!is_load && head.cell_y[0] && !BSEL[1]);
      hz = head.cell_z[IDX_W-1:1] +
           (IDX_W - 1)'(!is_load && head.cell_z[0] && !BSEL[0]);
      addr = {AW_X'(hx), AW_Y'(hy), AW_Z'(hz)};
      we   = pop && is_load &&
             ({head.cell_x[0], head.cell_y[0], head.cell_z[0]} == BSEL);
    end

    ttint_bank #(.AW(AW)) u_bank (
      .clk   (clk),
      .we    (we),
      .re    (en),
      .waddr (addr),
      .raddr (addr),
      .wdata (head.load_value),
      .rdata (rd[b])
    );
  end

  // valid and range flags travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[STAGES-2:0], pop && !is_load};
      out_valid <= vld[STAGES-1];
    end
  end

  // bank 0 side of an axis holds the upper corner when the lower index is odd,
  // so that lerp runs with the fraction mirrored
  always_ff @(posedge clk) begin
    if (en) begin
      rng   <= {rng[STAGES-2:0], head.op == OP_RANGE};
      fr[0] <= {head.cell_z[0] ? FRAC_ONE - FW'(head.frac_z) : FW'(head.frac_z),
                head.cell_y[0] ? FRAC_ONE - FW'(head.frac_y) : FW'(head.frac_y),
                head.cell_x[0] ? FRAC_ONE - FW'(head.frac_x) : FW'(head.frac_x)};
      for (int s = 1; s < STAGES - 1; s++) fr[s] <= fr[s-1];
    end
  end

  logic [VALUE_W-1:0]       a1 [4];
  logic signed [DW-1:0]     d1 [4];
  logic [VALUE_W-1:0]       a2 [4];
  logic signed [PW-1:0]     p2 [4];
  logic [VALUE_W-1:0]       cx [4];
  logic [VALUE_W-1:0]       a3 [2];
  logic signed [DW-1:0]     d3 [2];
  logic [VALUE_W-1:0]       a4 [2];
  logic signed [PW-1:0]     p4 [2];
  logic [VALUE_W-1:0]       cy [2];
  logic [VALUE_W-1:0]       a5;
  logic signed [DW-1:0]     d5;
  logic [VALUE_W-1:0]       a6;
  logic signed [PW-1:0]     p6;

  always_comb begin
    for (int j = 0; j < 4; j++) cx[j] = lerp_sum(a2[j], p2[j]);
    for (int m = 0; m < 2; m++) cy[m] = lerp_sum(a4[m], p4[m]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // x level: lane {by,bz} pairs bank bx=0 with bank bx=1
      for (int j = 0; j < 4; j++) begin
        a1[j] <= rd[j];
        d1[j] <= diff(rd[j], rd[j + 4]);
        a2[j] <= a1[j];
        p2[j] <= d1[j] * $signed({1'b0, fr[1][FW-1:0]});
      end
      // y level: lane bz pairs by=0 with by=1
      for (int m = 0; m < 2; m++) begin
        a3[m] <= cx[m];
        d3[m] <= diff(cx[m], cx[m + 2]);
        a4[m] <= a3[m];
        p4[m] <= d3[m] * $signed({1'b0, fr[3][2*FW-1:FW]});
      end
      // z level
      a5 <= cy[0];
      d5 <= diff(cy[0], cy[1]);
      a6 <= a5;
      p6 <= d5 * $signed({1'b0, fr[5][3*FW-1:2*FW]});
      interp_value <= rng[STAGES-1] ? '0 : $signed(lerp_sum(a6, p6));
      out_of_range <= rng[STAGES-1];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/trilinear_table_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// trilinear table interpolator top level
//
// input channel (in_valid / in_stall): one transaction per cycle while in_stall
// is low. cmd 0 loads load_value into the table entry at (index_x, index_y,
// index_z); loads outside the table are ignored, and no load gives a result.
// cmd 1 queries the cell whose upper corner is the index triple; the result
// carries the trilinear value of the eight corners, or out_of_range set and
// zero when the cell is not in the table. fractions above one are taken as one.
// output channel (out_valid / out_stall): one transaction per query, in order.
// throughput: one transaction per cycle while out_stall is low. the table is
// split into eight banks by index parity, so each corner of a cell comes from
// its own bank read port.
// a stalled output freezes the whole back end; the four-entry queue keeps
// taking transactions until it fills, then in_stall rises.
// reset clears the queue and the pipeline valid flags. table contents are not
// cleared and must be loaded before they are queried.
module trilinear_table_interpolator #(
  parameter int SIZE_X    = 16,
  parameter int SIZE_Y    = 16,
  parameter int SIZE_Z    = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 cmd,
  input  wire logic [ttint_pkg::IDX_W-1:0]          index_x,
  input  wire logic [ttint_pkg::IDX_W-1:0]          index_y,
  input  wire logic [ttint_pkg::IDX_W-1:0]          index_z,
  input  wire logic [ttint_pkg::FRAC_W-1:0]         frac_x,
  input  wire logic [ttint_pkg::FRAC_W-1:0]         frac_y,
  input  wire logic [ttint_pkg::FRAC_W-1:0]         frac_z,
  input  wire logic signed [ttint_pkg::VALUE_W-1:0] load_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [ttint_pkg::VALUE_W-1:0]      interp_value,
  output logic                                      out_of_range
);
  import ttint_pkg::*;

  logic        q_push;
  logic        q_pop;
  queue_item_t q_item;
  queue_item_t q_head;
  queue_stat_t q_stat;

  // front end classifies the transaction and folds the query to its lower corner
  ttint_front #(
    .SIZE_X    (SIZE_X),
    .SIZE_Y    (SIZE_Y),
    .SIZE_Z    (SIZE_Z),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_valid   (in_valid),
    .cmd        (cmd),
    .index_x    (index_x),
    .index_y    (index_y),
    .index_z    (index_z),
    .frac_x     (frac_x),
    .frac_y     (frac_y),
    .frac_z     (frac_z),
    .load_value (load_value),
    .stat       (q_stat),
    .in_stall   (in_stall),
    .push       (q_push),
    .item       (q_item)
  );

  // decouples input acceptance from back end stalls
  ttint_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .pop       (q_pop),
    .push_item (q_item),
    .head      (q_head),
    .stat      (q_stat)
  );

  // loads write the banks in queue order, so a later query sees them
  ttint_back #(
    .SIZE_X    (SIZE_X),
    .SIZE_Y    (SIZE_Y),
    .SIZE_Z    (SIZE_Z),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .stat         (q_stat),
    .pop          (q_pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .interp_value (interp_value),
    .out_of_range (out_of_range)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("queue push while full");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_stat.empty))
    else $error("queue pop while empty");

  a_range_gives_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> interp_value == '0)
    else $error("out of range result with nonzero value");

endmodule
`default_nettype wire

FILE: test/trilinear_table_interpolator_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the trilinear table interpolator
module trilinear_table_interpolator_tb;
  import ttint_pkg::*;

  // table geometry and fixed point format of the block as built
  localparam int     AXIS  = 16;
  localparam int     FBITS = 16;
  localparam longint ONE   = longint'(1) << FBITS;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(ONE);
  localparam logic [FRAC_W-1:0] FRAC_TOP = '1;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // command codes on the cmd input
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // run shape
  localparam int N_ITEMS        = 1800;
  localparam int IDLE_PCT       = 21;
  localparam int QUIET_FROM     = 1500;  // cycle window with no idling on either side
  localparam int QUIET_TO       = 2300;
  localparam int HOLD_AFTER     = 200;   // results seen before the long output hold
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;    // margin after the last result

  // one input transaction
  typedef struct {
    logic                      cmd;
    logic [IDX_W-1:0]          ix;
    logic [IDX_W-1:0]          iy;
    logic [IDX_W-1:0]          iz;
    logic [FRAC_W-1:0]         fx;
    logic [FRAC_W-1:0]         fy;
    logic [FRAC_W-1:0]         fz;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  // one output transaction
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      oor;
  } answer_t;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic                      cmd          = CMD_LOAD;
  logic [IDX_W-1:0]          index_x      = '0;
  logic [IDX_W-1:0]          index_y      = '0;
  logic [IDX_W-1:0]          index_z      = '0;
  logic [FRAC_W-1:0]         frac_x       = '0;
  logic [FRAC_W-1:0]         frac_y       = '0;
  logic [FRAC_W-1:0]         frac_z       = '0;
  logic signed [VALUE_W-1:0] load_value   = '0;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  logic signed [VALUE_W-1:0] interp_value;
  logic                      out_of_range;

  request_t request_q[$];   // transactions still to be offered
  answer_t  answer_q[$];    // query results owed by the block, oldest first
  request_t cur_req;        // transaction on the input port right now
  answer_t  want;

  // generator's view of which entries hold a value already
  bit loaded[AXIS][AXIS][AXIS];
  // predictor's copy of the table
  logic signed [VALUE_W-1:0] entry_model[AXIS][AXIS][AXIS];

  int   cyc          = 0;
  int   failures     = 0;
  int   results_seen = 0;
  int   hold_left    = 0;
  bit   hold_done    = 1'b0;
  int   stuck_cycles = 0;
  logic quiet;

  assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  trilinear_table_interpolator dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // ---------------------------------------------------------------- predictor

  // one linear step: exact weighted sum, then floor by the fraction width
  function automatic longint lerp_q(longint a, longint b, longint f);
    return (a * (ONE - f) + b * f) >>> FBITS;
  endfunction

  // result of a query against the current table copy
  function automatic answer_t interpolate_query(request_t r);
    answer_t ans;
    longint  fx, fy, fz;
    longint  c00, c10, c01, c11, c0, c1, res;
    int      x, y, z;
    x = int'(r.ix);
    y = int'(r.iy);
    z = int'(r.iz);
    ans.value = '0;
    ans.oor   = 1'b1;
    // a zero upper corner has no lower corner: flagged, value zero
    if (x == 0 || y == 0 || z == 0) return ans;
    // fractions above one count as one
    fx = (r.fx > FRAC_ONE) ? ONE : longint'(r.fx);
    fy = (r.fy > FRAC_ONE) ? ONE : longint'(r.fy);
    fz = (r.fz > FRAC_ONE) ? ONE : longint'(r.fz);
    // along x first
    c00 = lerp_q(longint'(entry_model[x-1][y-1][z-1]),
                 longint'(entry_model[x][y-1][z-1]), fx);
    c10 = lerp_q(longint'(entry_model[x-1][y][z-1]),
                 longint'(entry_model[x][y][z-1]), fx);
    c01 = lerp_q(longint'(entry_model[x-1][y-1][z]),
                 longint'(entry_model[x][y-1][z]), fx);
    c11 = lerp_q(longint'(entry_model[x-1][y][z]),
                 longint'(entry_model[x][y][z]), fx);
    // then y, then z
    c0  = lerp_q(c00, c10, fy);
    c1  = lerp_q(c01, c11, fy);
    res = lerp_q(c0, c1, fz);
    ans.value = res[VALUE_W-1:0];
    ans.oor   = 1'b0;
    return ans;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // fraction with weight on zero, exactly one and above one
  function automatic logic [FRAC_W-1:0] pick_frac();
    case ($urandom_range(7))
      0:       return '0;
      1:       return FRAC_ONE;
      2:       return FRAC_W'($urandom_range(FRAC_TOP, FRAC_ONE + 1));
      default: return FRAC_W'($urandom_range(FRAC_ONE));
    endcase
  endfunction

  // table value with weight on the extremes of the range
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // frac fields of a load are noise, the block must not care
  task automatic push_load(input int x, input int y, input int z,
                           input logic signed [VALUE_W-1:0] v);
    request_t r;
    r.cmd   = CMD_LOAD;
    r.ix    = IDX_W'(x);
    r.iy    = IDX_W'(y);
    r.iz    = IDX_W'(z);
    r.fx    = pick_frac();
    r.fy    = pick_frac();
    r.fz    = pick_frac();
    r.value = v;
    request_q.push_back(r);
    loaded[x][y][z] = 1'b1;
  endtask

  // load_value of a query is noise as well
  task automatic push_query(input int x, input int y, input int z,
                            input logic [FRAC_W-1:0] fx, input logic [FRAC_W-1:0] fy,
                            input logic [FRAC_W-1:0] fz);
    request_t r;
    r.cmd   = CMD_QUERY;
    r.ix    = IDX_W'(x);
    r.iy    = IDX_W'(y);
    r.iz    = IDX_W'(z);
    r.fx    = fx;
    r.fy    = fy;
    r.fz    = fz;
    r.value = pick_value();
    request_q.push_back(r);
  endtask

  initial begin
    int x, y, z;
    int last_x, last_y, last_z;
    int sel;

    // lowest cell, corners alternating between the most positive and most
    // negative entry so every lerp stage sees full-scale swings
    for (int dx = 0; dx < 2; dx++)
      for (int dy = 0; dy < 2; dy++)
        for (int dz = 0; dz < 2; dz++)
          push_load(dx, dy, dz, ((dx ^ dy ^ dz) != 0) ? VAL_MAX : VAL_MIN);
    push_query(1, 1, 1, '0, '0, '0);                    // exactly the lower corner
    push_query(1, 1, 1, FRAC_ONE, FRAC_ONE, FRAC_ONE);  // exactly the upper corner
    push_query(1, 1, 1, FRAC_ONE >> 1, FRAC_ONE >> 1, FRAC_ONE >> 1);
    push_query(1, 1, 1, FRAC_TOP, FRAC_ONE + 1, FRAC_TOP);  // fractions saturate
    // a zero index on each axis in turn
    push_query(0, 5, 5, FRAC_TOP, '0, FRAC_ONE);
    push_query(5, 0, 5, '0, FRAC_TOP, '0);
    push_query(5, 5, 0, FRAC_ONE, FRAC_ONE, FRAC_TOP);
    // highest cell, zero and minus one corners
    for (int dx = 0; dx < 2; dx++)
      for (int dy = 0; dy < 2; dy++)
        for (int dz = 0; dz < 2; dz++)
          push_load(14 + dx, 14 + dy, 14 + dz, ((dx + dy + dz) % 2 != 0) ? '0 : '1);
    push_query(15, 15, 15, 17'h0ffff, 17'h00001, 17'h08000);

    last_x = 1;
    last_y = 1;
    last_z = 1;
    while (request_q.size() < N_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        // well-formed: load the missing corners (and refresh some), then query
        x = $urandom_range(AXIS - 1, 1);
        y = $urandom_range(AXIS - 1, 1);
        z = $urandom_range(AXIS - 1, 1);
        for (int dx = 0; dx < 2; dx++)
          for (int dy = 0; dy < 2; dy++)
            for (int dz = 0; dz < 2; dz++)
              if (!loaded[x-1+dx][y-1+dy][z-1+dz] || $urandom_range(3) == 0)
                push_load(x - 1 + dx, y - 1 + dy, z - 1 + dz, pick_value());
        push_query(x, y, z, pick_frac(), pick_frac(), pick_frac());
        last_x = x;
        last_y = y;
        last_z = z;
      end else if (sel < 60) begin
        // same cell again, new position within it
        push_query(last_x, last_y, last_z, pick_frac(), pick_frac(), pick_frac());
      end else if (sel < 80) begin
        // stray load anywhere, may overwrite a live corner
        push_load($urandom_range(AXIS - 1), $urandom_range(AXIS - 1),
                  $urandom_range(AXIS - 1), pick_value());
      end else begin
        // query with a zero corner index, never touches the table
        x = $urandom_range(AXIS - 1);
        y = $urandom_range(AXIS - 1);
        z = $urandom_range(AXIS - 1);
        case ($urandom_range(2))
          0:       x = 0;
          1:       y = 0;
          default: z = 0;
        endcase
        push_query(x, y, z, pick_frac(), pick_frac(), pick_frac());
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // every transaction taken, then every result back, then a short drain
    do @(negedge clk); while (request_q.size() != 0 || in_valid);
    while (answer_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("trilinear_table_interpolator regression: pass");
    end else begin
      $display("trilinear_table_interpolator regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  // a transaction is predicted at the edge that accepts it; a new one is only
  // put on the port once the previous one is gone, so stalled payload holds
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (cur_req.cmd == CMD_LOAD) begin
          entry_model[cur_req.ix][cur_req.iy][cur_req.iz] = cur_req.value;
        end else begin
          answer_q.push_back(interpolate_query(cur_req));
        end
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          cur_req = request_q.pop_front();
          in_valid   <= 1'b1;
          cmd        <= cur_req.cmd;
          index_x    <= cur_req.ix;
          index_y    <= cur_req.iy;
          index_z    <= cur_req.iz;
          frac_x     <= cur_req.fx;
          frac_y     <= cur_req.fy;
          frac_z     <= cur_req.fz;
          load_value <= cur_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          $error("result with no query pending: interp_value %0d out_of_range %0b",
                 interp_value, out_of_range);
          failures++;
        end else begin
          want = answer_q.pop_front();
          if (interp_value !== want.value) begin
            $error("interp_value: expected %0d, got %0d", want.value, interp_value);
            failures++;
          end
          if (out_of_range !== want.oor) begin
            $error("out_of_range: expected %0b, got %0b", want.oor, out_of_range);
            failures++;
          end
        end
      end
      // one long hold so the queue fills and back-pressure reaches the input
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("trilinear_table_interpolator regression: fail");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
hw/rtl/ttint_pkg.sv
hw/rtl/ttint_front.sv
hw/rtl/ttint_queue.sv
hw/rtl/ttint_bank.sv
hw/rtl/ttint_back.sv
hw/rtl/trilinear_table_interpolator.sv
test/trilinear_table_interpolator_tb.sv
